[rtl/mps_pkg.sv]
// Package for the multipath path selector: sizes, beat structs, register codes,
// FSM states and the saturating deadline add. No dependencies.
package mps_pkg;

  localparam int HOSTS = 4;
  localparam int PATHS = 4;
  localparam int CONNS = 1024;

  localparam int NCONN    = HOSTS * CONNS;
  localparam int ADDR_W   = $clog2(NCONN);
  localparam int PATH_W   = 2;
  localparam int HOST_W   = 2;
  localparam int CONN_W   = 10;
  localparam int LINK_W   = 4;
  localparam int TICK_W   = 32;
  localparam int QUOTA_W  = 16;
  localparam int CD_W     = 4;
  localparam int QUOTA_N  = 4;
  localparam int CFG_IDX_W = 4;

  localparam logic [CD_W-1:0] CD_LOAD = CD_W'((3 * PATHS) % (1 << CD_W));

  typedef logic [ADDR_W-1:0] conn_addr_t;

  typedef struct packed {
    logic              command;
    logic [HOST_W-1:0] host_index;
    logic [CONN_W-1:0] conn_index;
    logic [PATH_W-1:0] rx_path;
    logic              syn_flag;
    logic [LINK_W-1:0] links_up;
    logic [TICK_W-1:0] now_ticks;
  } in_item_t;

  typedef struct packed {
    logic              dropped;
    logic [PATH_W-1:0] chosen_path;
    logic              path_changed;
  } out_item_t;

  typedef struct packed {
    logic [QUOTA_W-1:0] quota_left;
    logic [CD_W-1:0]    countdown;
    logic [PATH_W-1:0]  path;
    logic [TICK_W-1:0]  burst_until;
    logic [TICK_W-1:0]  hold_until;
  } conn_entry_t;

  typedef struct packed {
    logic        we;
    conn_addr_t  addr;
    conn_entry_t data;
  } conn_wr_t;

  typedef struct packed {
    logic [QUOTA_N-1:0][QUOTA_W-1:0] quota;
    logic [TICK_W-1:0]               burst_ticks;
    logic [TICK_W-1:0]               hold_ticks;
    logic [TICK_W-1:0]               liveness_ticks;
    logic                            liveness_check;
  } cfg_t;

  typedef logic [PATHS-1:0][TICK_W-1:0] alive_row_t;

  typedef struct packed {
    out_item_t         res;
    logic              conn_we;
    conn_entry_t       entry;
    logic              alive_we;
    logic [TICK_W-1:0] alive_until;
  } decision_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUOTA0 = 4'd0,
    CFG_QUOTA1 = 4'd1,
    CFG_QUOTA2 = 4'd2,
    CFG_QUOTA3 = 4'd3,
    CFG_BURST  = 4'd4,
    CFG_HOLD   = 4'd5,
    CFG_LIVE   = 4'd6,
    CFG_CHECK  = 4'd7
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_e;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  function automatic logic [TICK_W-1:0] sat_add(input logic [TICK_W-1:0] a,
                                                input logic [TICK_W-1:0] b);
    logic [TICK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TICK_W] ? '1 : s[TICK_W-1:0];
  endfunction

endpackage

[rtl/mps_conn_store.sv]
// Per-connection table: one synchronous RAM, registered read, one write port.
// Runs a clearing sweep after reset. Depends on mps_pkg.
module mps_conn_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  mps_pkg::conn_addr_t rd_addr_i,
  output mps_pkg::conn_entry_t rd_data_o,
  input  mps_pkg::conn_wr_t   wr_i,
  output logic                clearing_o
);

  mps_pkg::conn_entry_t mem [mps_pkg::NCONN];
  mps_pkg::conn_entry_t rd_data_q;

  logic                clear_q, clear_d;
  mps_pkg::conn_addr_t clr_addr_q, clr_addr_d;

  always_comb begin
    clear_d    = clear_q;
    clr_addr_d = clr_addr_q;
    if (clear_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == mps_pkg::conn_addr_t'(mps_pkg::NCONN - 1)) begin
        clear_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q    <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clear_q    <= clear_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clear_q;

endmodule

[rtl/mps_decide.sv]
// Path decision for one beat: keep test, rotating search, entry update and
// receive refresh. Purely combinational. Depends on mps_pkg.
module mps_decide (
  input  mps_pkg::in_item_t    item_i,
  input  mps_pkg::conn_entry_t entry_i,
  input  mps_pkg::cfg_t        cfg_i,
  input  mps_pkg::alive_row_t  alive_i,
  output mps_pkg::decision_t   dec_o
);

  always_comb begin
    logic [mps_pkg::PATHS-1:0]      usable;
    logic [mps_pkg::PATHS-1:0]      alive_ok;
    logic [mps_pkg::CD_W-1:0]       cd;
    logic [mps_pkg::QUOTA_W-1:0]    quota;
    logic [mps_pkg::PATH_W-1:0]     old;
    logic [mps_pkg::PATH_W-1:0]     sel;
    logic [mps_pkg::PATH_W:0]       cand;
    logic                           keep;
    logic                           found;
    logic [mps_pkg::TICK_W-1:0]     now;
    mps_pkg::conn_entry_t           nxt;

    now      = item_i.now_ticks;
    usable   = '0;
    alive_ok = '0;
    for (int p = 0; p < mps_pkg::PATHS; p++) begin
      alive_ok[p] = !cfg_i.liveness_check || (alive_i[p] >= now);
      usable[p]   = (cfg_i.quota[p] != '0) && item_i.links_up[p] && alive_ok[p];
    end

    dec_o             = '0;
    dec_o.res.dropped = 1'b1;
    dec_o.alive_until = mps_pkg::sat_add(now, cfg_i.liveness_ticks);

    cd    = item_i.syn_flag ? mps_pkg::CD_LOAD : entry_i.countdown;
    quota = entry_i.quota_left;
    if (cd != '0) begin
      cd    = cd - 1'b1;
      quota = '0;
    end
    old  = mps_pkg::PATH_W'(entry_i.path % mps_pkg::PATHS);
    keep = (quota != '0) && (entry_i.burst_until >= now) && (entry_i.hold_until >= now)
           && alive_ok[old] && item_i.links_up[old];

    // rotate starting after the current path, ending on it
    found = 1'b0;
    sel   = old;
    for (int i = 1; i <= mps_pkg::PATHS; i++) begin
      cand = {1'b0, old} + (mps_pkg::PATH_W+1)'(i);
      if (cand >= (mps_pkg::PATH_W+1)'(mps_pkg::PATHS)) begin
        cand = cand - (mps_pkg::PATH_W+1)'(mps_pkg::PATHS);
      end
      if (!found && usable[cand[mps_pkg::PATH_W-1:0]]) begin
        found = 1'b1;
        sel   = cand[mps_pkg::PATH_W-1:0];
      end
    end

    nxt            = entry_i;
    nxt.countdown  = cd;
    nxt.quota_left = quota;

    if (item_i.command == mps_pkg::CMD_RECV) begin
      if (32'(item_i.host_index) < mps_pkg::HOSTS &&
          32'(item_i.rx_path) < mps_pkg::PATHS) begin
        dec_o.alive_we        = 1'b1;
        dec_o.res.dropped     = 1'b0;
        dec_o.res.chosen_path = item_i.rx_path;
      end
    end else if (32'(item_i.host_index) < mps_pkg::HOSTS &&
                 32'(item_i.conn_index) < mps_pkg::CONNS) begin
      dec_o.conn_we = 1'b1;
      if (keep) begin
        nxt.quota_left        = quota - 1'b1;
        nxt.burst_until       = mps_pkg::sat_add(now, cfg_i.burst_ticks);
        dec_o.res.dropped     = 1'b0;
        dec_o.res.chosen_path = old;
      end else if (found) begin
        if (sel != old) begin
          nxt.path               = sel;
          nxt.quota_left         = cfg_i.quota[sel];
          nxt.hold_until         = mps_pkg::sat_add(now, cfg_i.hold_ticks);
          dec_o.res.path_changed = 1'b1;
        end
        nxt.burst_until       = mps_pkg::sat_add(now, cfg_i.burst_ticks);
        dec_o.res.dropped     = 1'b0;
        dec_o.res.chosen_path = sel;
      end
      // no usable path: only the SYN countdown and quota clear are written back
    end
    dec_o.entry = nxt;
  end

endmodule

[rtl/multipath_connection_path_selector_unit.sv]
// Top level of the multipath path selector: handshakes, configuration
// registers, path liveness table, FSM and result register. Uses mps_pkg,
// mps_conn_store and mps_decide.
//
//  channel  dir  handshake                   payload
//  in       in   in_valid_i / in_ready_o     in_data_i   (mps_pkg::in_item_t)
//  out      out  out_valid_o / out_ready_i   out_data_o  (mps_pkg::out_item_t)
//  cfg      in   cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// Each beat is accepted in ST_IDLE, which reads the connection RAM into its read
// register; ST_CALC then writes the updated entry and loads the result register,
// waiting while an earlier result is unread. One beat is in flight at a time.
// After reset a clearing sweep over all 4096 entries zeroes the connection RAM; no
// input beat is taken meanwhile, configuration writes always are.
// A stalled result holds the decision step; the next input beat can still be
// accepted while a result waits.
module multipath_connection_path_selector_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mps_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mps_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);

  mps_pkg::state_e     state_q, state_d;
  mps_pkg::cfg_t       cfg_q;
  mps_pkg::in_item_t   item_q;
  mps_pkg::alive_row_t alive_q [mps_pkg::HOSTS];
  mps_pkg::out_item_t  out_data_q;
  logic                out_valid_q, out_valid_d;

  mps_pkg::conn_entry_t rd_data;
  mps_pkg::conn_wr_t    conn_wr;
  mps_pkg::decision_t   dec;
  mps_pkg::conn_addr_t  rd_addr;
  logic                 clearing;
  logic                 in_fire;
  logic                 calc_go;

  assign in_ready_o  = (state_q == mps_pkg::ST_IDLE) && !clearing;
  assign in_fire     = in_valid_i && in_ready_o;
  assign calc_go     = (state_q == mps_pkg::ST_CALC) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;

  assign rd_addr = mps_pkg::conn_addr_t'(in_data_i.host_index)
                   * mps_pkg::conn_addr_t'(mps_pkg::CONNS)
                   + mps_pkg::conn_addr_t'(in_data_i.conn_index);

  mps_conn_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_fire),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .wr_i       (conn_wr),
    .clearing_o (clearing)
  );

  mps_decide u_decide (
    .item_i  (item_q),
    .entry_i (rd_data),
    .cfg_i   (cfg_q),
    .alive_i (alive_q[item_q.host_index]),
    .dec_o   (dec)
  );

  always_comb begin
    conn_wr.we   = calc_go && dec.conn_we;
    conn_wr.addr = mps_pkg::conn_addr_t'(item_q.host_index)
                   * mps_pkg::conn_addr_t'(mps_pkg::CONNS)
                   + mps_pkg::conn_addr_t'(item_q.conn_index);
    conn_wr.data = dec.entry;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      mps_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = mps_pkg::ST_CALC;
        end
      end
      mps_pkg::ST_CALC: begin
        if (calc_go) begin
          state_d     = mps_pkg::ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = mps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mps_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (calc_go) begin
      out_data_q <= dec.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int h = 0; h < mps_pkg::HOSTS; h++) begin
        alive_q[h] <= '0;
      end
    end else if (calc_go && dec.alive_we) begin
      alive_q[item_q.host_index][item_q.rx_path] <= dec.alive_until;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < mps_pkg::QUOTA_N; p++) begin
        cfg_q.quota[p] <= 16'd1000;
      end
      cfg_q.burst_ticks    <= 32'd25;
      cfg_q.hold_ticks     <= 32'd1000;
      cfg_q.liveness_ticks <= 32'd3500;
      cfg_q.liveness_check <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mps_pkg::CFG_QUOTA0: cfg_q.quota[0]       <= cfg_data_i[15:0];
        mps_pkg::CFG_QUOTA1: cfg_q.quota[1]       <= cfg_data_i[15:0];
        mps_pkg::CFG_QUOTA2: cfg_q.quota[2]       <= cfg_data_i[15:0];
        mps_pkg::CFG_QUOTA3: cfg_q.quota[3]       <= cfg_data_i[15:0];
        mps_pkg::CFG_BURST:  cfg_q.burst_ticks    <= cfg_data_i;
        mps_pkg::CFG_HOLD:   cfg_q.hold_ticks     <= cfg_data_i;
        mps_pkg::CFG_LIVE:   cfg_q.liveness_ticks <= cfg_data_i;
        mps_pkg::CFG_CHECK:  cfg_q.liveness_check <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_ready_o)
    else $error("input beat offered ready during RAM clear");

  a_calc_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == mps_pkg::ST_CALC) |-> $past(in_fire))
    else $error("decision step entered without an accepted beat");

  a_result_from_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(calc_go))
    else $error("result raised without a decision step");

  a_write_only_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conn_wr.we |-> (state_q == mps_pkg::ST_CALC) && !clearing)
    else $error("connection RAM written outside the decision step");

endmodule
